// ----- hw/rtl/crse_pkg.sv -----
package crse_pkg;

    // Fixed widths of the payload fields that do not follow a parameter.
    localparam int T_PARAM_WIDTH = 16;
    localparam int AXIS_WIDTH    = 2;

    // Register stages from the input to the output register.
    localparam int NUM_STAGES = 7;

    // Load enables for the three stages of the basis weight unit.
    typedef struct packed {
        logic t_sq;
        logic t_cube;
        logic weight;
    } crse_basis_ld_t;

endpackage

// ----- hw/rtl/crse_if.sv -----
// Input channel: curve parameter, four control coordinates and the axis tag.
interface crse_in_if #(
    parameter int COORD_WIDTH = 32
) ();
    import crse_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [T_PARAM_WIDTH-1:0]      t_param;
    logic signed [COORD_WIDTH-1:0] ctrl_a;
    logic signed [COORD_WIDTH-1:0] ctrl_b;
    logic signed [COORD_WIDTH-1:0] ctrl_c;
    logic signed [COORD_WIDTH-1:0] ctrl_d;
    logic [AXIS_WIDTH-1:0]         axis_tag;

    modport source (
        output valid, t_param, ctrl_a, ctrl_b, ctrl_c, ctrl_d, axis_tag,
        input  ready
    );

    modport sink (
        input  valid, t_param, ctrl_a, ctrl_b, ctrl_c, ctrl_d, axis_tag,
        output ready
    );
endinterface

// Output channel: interpolated coordinate, axis tag and saturation flag.
interface crse_out_if #(
    parameter int COORD_WIDTH = 32
) ();
    import crse_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] curve_value;
    logic [AXIS_WIDTH-1:0]         axis_out;
    logic                          clipped;

    modport source (
        output valid, curve_value, axis_out, clipped,
        input  ready
    );

    modport sink (
        input  valid, curve_value, axis_out, clipped,
        output ready
    );
endinterface

// ----- hw/rtl/crse_basis.sv -----
// Three-stage unit that forms t squared, t cubed and the four doubled
// Catmull-Rom basis weights with T_FRAC_BITS fraction bits.
module crse_basis #(
    parameter int T_FRAC_BITS = 15
) (
    input  logic                                clk,
    input  crse_pkg::crse_basis_ld_t            ld,
    input  logic [crse_pkg::T_PARAM_WIDTH-1:0]  t_param,
    output logic signed [T_FRAC_BITS+3:0]       weight [4]
);
    import crse_pkg::*;

    // The clamped parameter never exceeds one, so it fits in F+1 bits.
    localparam int TW  = T_FRAC_BITS + 1;
    localparam int TXW = (T_PARAM_WIDTH > TW) ? T_PARAM_WIDTH : TW;
    localparam int WW  = T_FRAC_BITS + 4;

    localparam logic [TXW-1:0]         ONE_X    = TXW'(1) << T_FRAC_BITS;
    localparam logic [2*TW-1:0]        HALF     = (2*TW)'(1) << (T_FRAC_BITS - 1);
    localparam logic signed [WW-1:0]   TWO_ONES = WW'(1) <<< (T_FRAC_BITS + 1);

    logic [TXW-1:0]   t_ext;
    logic [TW-1:0]    t_clamp;
    logic [2*TW-1:0]  sq_round;
    logic [2*TW-1:0]  cu_round;

    logic [TW-1:0]    t_s0_reg;
    logic [TW-1:0]    t2_s0_reg;
    logic [TW-1:0]    t_s1_reg;
    logic [TW-1:0]    t2_s1_reg;
    logic [TW-1:0]    t3_s1_reg;

    logic signed [WW-1:0] t_w;
    logic signed [WW-1:0] t2_w;
    logic signed [WW-1:0] t3_w;
    logic signed [WW-1:0] weight_next [4];
    logic signed [WW-1:0] weight_reg  [4];

    // Clamp the parameter to one and square it, rounding half up.
    always_comb
    begin
        t_ext    = TXW'(t_param);
        t_clamp  = (t_ext > ONE_X) ? ONE_X[TW-1:0] : t_ext[TW-1:0];
        sq_round = t_clamp * t_clamp + HALF;
    end

    always_ff @(posedge clk)
    begin
        if (ld.t_sq)
        begin
            t_s0_reg  <= t_clamp;
            t2_s0_reg <= sq_round[T_FRAC_BITS +: TW];
        end
    end

    // Cube from the rounded square, again rounding half up.
    assign cu_round = t2_s0_reg * t_s0_reg + HALF;

    always_ff @(posedge clk)
    begin
        if (ld.t_cube)
        begin
            t_s1_reg  <= t_s0_reg;
            t2_s1_reg <= t2_s0_reg;
            t3_s1_reg <= cu_round[T_FRAC_BITS +: TW];
        end
    end

    // Doubled basis weights, built from shifts and adds.
    always_comb
    begin
        t_w  = $signed({3'b000, t_s1_reg});
        t2_w = $signed({3'b000, t2_s1_reg});
        t3_w = $signed({3'b000, t3_s1_reg});
        weight_next[0] = (t2_w <<< 1) - t3_w - t_w;
        weight_next[1] = (t3_w <<< 1) + t3_w - (t2_w <<< 2) - t2_w + TWO_ONES;
        weight_next[2] = (t2_w <<< 2) + t_w - (t3_w <<< 1) - t3_w;
        weight_next[3] = t3_w - t2_w;
    end

    always_ff @(posedge clk)
    begin
        if (ld.weight)
        begin
            for (int i = 0; i < 4; i++)
            begin
                weight_reg[i] <= weight_next[i];
            end
        end
    end

    assign weight = weight_reg;

endmodule

// ----- hw/rtl/catmull_rom_spline_eval_core.sv -----
// Channel   Direction  Handshake     Payload
// samples   in         valid/ready   t_param, ctrl_a..ctrl_d, axis_tag
// results   out        valid/ready   curve_value, axis_out, clipped
//
// One item is accepted per cycle while results.ready stays high; the seven
// register stages (square, cube, weights, partial products, products, pair
// sums, round and saturate) each hold one item.
// rst_n clears the stage valid bits asynchronously; payload is not reset.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// are filled during a stall and no item is dropped or repeated.
module catmull_rom_spline_eval_core #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    crse_in_if.sink       samples,
    crse_out_if.source    results
);
    import crse_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int WW   = T_FRAC_BITS + 4;
    localparam int LO_W = CW / 2;
    localparam int HI_W = CW - LO_W;
    localparam int PW   = CW + WW;
    localparam int AW   = PW + 2;
    localparam int SW   = AW - T_FRAC_BITS - 1;

    localparam logic signed [AW-1:0] ROUND  = AW'(1) <<< T_FRAC_BITS;
    localparam logic signed [CW-1:0] CW_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CW_MIN = {1'b1, {(CW-1){1'b0}}};

    // Stage indexes that carry payload of their own.
    localparam int ST_PART = 3;
    localparam int ST_PROD = 4;
    localparam int ST_PAIR = 5;
    localparam int ST_OUT  = 6;

    logic [NUM_STAGES-1:0]  ld;
    logic [NUM_STAGES-1:0]  v_reg;
    logic [NUM_STAGES-1:0]  v_next;
    crse_basis_ld_t         basis_ld;

    logic [AXIS_WIDTH-1:0]  axis_reg [NUM_STAGES];
    logic signed [CW-1:0]   ctrl_reg [3][4];
    logic signed [WW-1:0]   weight   [4];

    logic signed [LO_W+WW:0]    pl_next [4];
    logic signed [HI_W+WW-1:0]  ph_next [4];
    logic signed [LO_W+WW:0]    pl_reg  [4];
    logic signed [HI_W+WW-1:0]  ph_reg  [4];
    logic signed [PW-1:0]       prod_next [4];
    logic signed [PW-1:0]       prod_reg  [4];
    logic signed [AW-1:0]       s01_reg;
    logic signed [AW-1:0]       s23_reg;

    logic signed [AW-1:0]       total;
    logic signed [SW-1:0]       shifted;
    logic [SW-CW:0]             top_bits;
    logic                       fits;
    logic signed [CW-1:0]       value_next;
    logic signed [CW-1:0]       value_reg;
    logic                       clip_reg;

    // Each stage loads when it is empty or its successor moves on.
    always_comb
    begin
        ld[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || results.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        v_next[0] = ld[0] ? samples.valid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            v_next[k] = ld[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    assign samples.ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Axis tag and control coordinates travel alongside the weight unit.
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            axis_reg[0]    <= samples.axis_tag;
            ctrl_reg[0][0] <= samples.ctrl_a;
            ctrl_reg[0][1] <= samples.ctrl_b;
            ctrl_reg[0][2] <= samples.ctrl_c;
            ctrl_reg[0][3] <= samples.ctrl_d;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (ld[k])
            begin
                axis_reg[k] <= axis_reg[k-1];
            end
        end
        for (int k = 1; k < 3; k++)
        begin
            if (ld[k])
            begin
                ctrl_reg[k] <= ctrl_reg[k-1];
            end
        end
    end

    // Basis weights for stages zero to two.
    assign basis_ld.t_sq   = ld[0];
    assign basis_ld.t_cube = ld[1];
    assign basis_ld.weight = ld[2];

    crse_basis #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_basis (
        .clk     (clk),
        .ld      (basis_ld),
        .t_param (samples.t_param),
        .weight  (weight)
    );

    // Partial products: low half of each coordinate unsigned, high half signed.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pl_next[i] = $signed({1'b0, ctrl_reg[2][i][LO_W-1:0]}) * weight[i];
            ph_next[i] = $signed(ctrl_reg[2][i][CW-1:LO_W]) * weight[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_PART])
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
    end

    // Recombine the two halves into the full product.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = (PW'(ph_reg[i]) <<< LO_W) + PW'(pl_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_PROD])
        begin
            prod_reg <= prod_next;
        end
    end

    // Pair sums; the rounding constant rides with the first pair.
    always_ff @(posedge clk)
    begin
        if (ld[ST_PAIR])
        begin
            s01_reg <= AW'(prod_reg[0]) + AW'(prod_reg[1]) + ROUND;
            s23_reg <= AW'(prod_reg[2]) + AW'(prod_reg[3]);
        end
    end

    // Final sum, halve with rounding, then saturate to the coordinate range.
    always_comb
    begin
        total      = s01_reg + s23_reg;
        shifted    = SW'(total >>> (T_FRAC_BITS + 1));
        top_bits   = shifted[SW-1:CW-1];
        fits       = (&top_bits) || !(|top_bits);
        value_next = fits ? shifted[CW-1:0] : (shifted[SW-1] ? CW_MIN : CW_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (ld[ST_OUT])
        begin
            value_reg <= value_next;
            clip_reg  <= !fits;
        end
    end

    assign results.valid       = v_reg[ST_OUT];
    assign results.curve_value = value_reg;
    assign results.axis_out    = axis_reg[ST_OUT];
    assign results.clipped     = clip_reg;

    // A clipped result always sits at one of the two range limits.
    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.clipped) |->
        (results.curve_value == CW_MAX || results.curve_value == CW_MIN))
        else $error("clipped result not at a range limit");

    // An accepted item occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> v_reg[0])
        else $error("accepted item missing from first stage");

    // Input backpressure only when every stage holds an item.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (&v_reg))
        else $error("input stalled with a free stage");

    // A ready consumer never blocks the input.
    a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
        results.ready |-> samples.ready)
        else $error("input stalled while output is ready");

endmodule
